### sv/header_checksum_frame_receiver_top_macros.svh
// Assertion macros for the frame receiver top module.
`ifndef HEADER_CHECKSUM_FRAME_RECEIVER_TOP_MACROS_SVH
`define HEADER_CHECKSUM_FRAME_RECEIVER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define HCFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcfr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcfr assertion failed");

`else

`define HCFR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/hcfr_pkg.sv
package hcfr_pkg;

    // Frame geometry.
    localparam int FRAME_LEN = 8;
    localparam int POS_W = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_LOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_CODE = 2'd2;
    localparam logic [7:0] HEADER_HIGH_RST = 8'hAB;
    localparam logic [7:0] HEADER_LOW_RST = 8'hCD;
    localparam logic [7:0] COMMAND_CODE_RST = 8'h00;

    // Result kinds.
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    // Microprogram addresses.
    typedef enum logic [3:0] {
        ST_FETCH     = 4'd0,
        ST_TEST_LAST = 4'd1,
        ST_TEST_HDR  = 4'd2,
        ST_STORE     = 4'd3,
        ST_FINAL     = 4'd4,
        ST_REJECT    = 4'd5,
        ST_GOOD      = 4'd6,
        ST_READ      = 4'd7,
        ST_EMIT      = 4'd8,
        ST_BACK      = 4'd9
    } step_t;

    // What a step waits for before it fires.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_IN,
        STALL_OUT
    } stall_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_LAST,
        C_SKIP,
        C_GOOD,
        C_ECHO_DONE
    } cond_t;

    // Datapath actions.
    typedef enum logic [2:0] {
        A_NONE,
        A_LATCH,
        A_STORE,
        A_FINAL,
        A_REJECT,
        A_GOOD,
        A_EMIT
    } act_t;

    typedef struct packed {
        stall_t stall;
        cond_t  cond;
        step_t  target;
        act_t   act;
    } ctrl_word_t;

    // Condition flags from the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic last;
        logic skip;
        logic good;
        logic echo_done;
    } dp_status_t;

    // Per-cycle control from the sequencer to the datapath.
    typedef struct packed {
        logic take_in;
        logic fire;
        act_t act;
    } seq_ctrl_t;

    // Microcode ROM: one control word per step.
    function automatic ctrl_word_t hcfr_rom(step_t s);
        ctrl_word_t w;
        w = '{stall: STALL_NONE, cond: C_ALWAYS, target: ST_FETCH, act: A_NONE};
        unique case (s)
            ST_FETCH:     w = '{STALL_IN,   C_NEVER,     ST_FETCH, A_LATCH};
            ST_TEST_LAST: w = '{STALL_NONE, C_LAST,      ST_FINAL, A_NONE};
            ST_TEST_HDR:  w = '{STALL_NONE, C_SKIP,      ST_FETCH, A_NONE};
            ST_STORE:     w = '{STALL_NONE, C_ALWAYS,    ST_FETCH, A_STORE};
            ST_FINAL:     w = '{STALL_NONE, C_GOOD,      ST_GOOD,  A_FINAL};
            ST_REJECT:    w = '{STALL_OUT,  C_ALWAYS,    ST_FETCH, A_REJECT};
            ST_GOOD:      w = '{STALL_NONE, C_NEVER,     ST_FETCH, A_GOOD};
            ST_READ:      w = '{STALL_NONE, C_NEVER,     ST_FETCH, A_NONE};
            ST_EMIT:      w = '{STALL_OUT,  C_ECHO_DONE, ST_FETCH, A_EMIT};
            ST_BACK:      w = '{STALL_NONE, C_ALWAYS,    ST_EMIT,  A_NONE};
            default:      w = '{STALL_NONE, C_ALWAYS,    ST_FETCH, A_NONE};
        endcase
        return w;
    endfunction

endpackage

### sv/hcfr_seq.sv
module hcfr_seq
    import hcfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output seq_ctrl_t  ctrl
);

    step_t      step_reg;
    step_t      step_next;
    ctrl_word_t cw;
    logic       fire;
    logic       cond_true;

    // Control word lookup and output decode.
    always_comb
    begin
        cw = hcfr_rom(step_reg);
        unique case (cw.stall)
            STALL_NONE: fire = 1'b1;
            STALL_IN:   fire = status.in_valid;
            STALL_OUT:  fire = status.out_free;
            default:    fire = 1'b0;
        endcase
        ctrl.take_in = (cw.stall == STALL_IN);
        ctrl.fire = fire;
        ctrl.act = cw.act;
    end

    // Condition select for the jump.
    always_comb
    begin
        unique case (cw.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_LAST:      cond_true = status.last;
            C_SKIP:      cond_true = status.skip;
            C_GOOD:      cond_true = status.good;
            C_ECHO_DONE: cond_true = status.echo_done;
            default:     cond_true = 1'b0;
        endcase
    end

    // Next step: hold while stalled, jump when the condition holds, else advance.
    always_comb
    begin
        priority if (!fire)
        begin
            step_next = step_reg;
        end
        else if (cond_true)
        begin
            step_next = cw.target;
        end
        else
        begin
            step_next = step_t'(step_reg + 4'd1);
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

### sv/header_checksum_frame_receiver_top.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+------------------------------------
// input    | in        | in_valid / in_ready     | rx_byte
// output   | out       | out_valid / out_ready   | kind, data_byte, last, good_count
// config   | in        | cfg_we (no wait)        | cfg_index, cfg_data
//
// A microcoded sequencer runs every byte through its steps: a dropped byte passes fetch, last test
// and header test, a stored byte then the store step, and a rejected final byte fetch, last test,
// final and reject, plus any output stall. A good final byte passes fetch, last test, final, good
// and read, then emit per echoed byte with a back step between echoes for the registered store read.
// Reset is asynchronous and active low; the frame store needs no clearing pass.
// An output stall holds the sequencer only in its output steps; the result register lets
// the next byte be taken while a result waits.

`include "header_checksum_frame_receiver_top_macros.svh"

module header_checksum_frame_receiver_top
    import hcfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 kind,
    output logic [7:0]           data_byte,
    output logic                 last,
    output logic [15:0]          good_count,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    dp_status_t status;
    seq_ctrl_t  ctrl;

    logic [7:0]       header_high_reg;
    logic [7:0]       header_low_reg;
    logic [7:0]       command_code_reg;
    logic [7:0]       byte_reg;
    logic             reading_reg;
    logic             reading_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [7:0]       cap1_reg;
    logic [7:0]       cap2_reg;
    logic [15:0]      count_reg;
    logic [15:0]      count_next;
    logic [POS_W-1:0] idx_reg;
    logic [POS_W-1:0] idx_next;
    logic [7:0]       rd_data_reg;
    logic [7:0]       store_mem [FRAME_LEN];
    logic             store_we;
    logic [POS_W-1:0] store_addr;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_kind_reg;
    logic [7:0]       out_data_reg;
    logic             out_last_reg;
    logic [15:0]      out_count_reg;
    logic             out_load;
    logic             do_latch;
    logic             do_store;
    logic             do_final;
    logic             do_reject;
    logic             do_good;
    logic             do_emit;

    // Sequencer.
    hcfr_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // Action decode, qualified by the step firing.
    assign do_latch  = ctrl.fire && (ctrl.act == A_LATCH);
    assign do_store  = ctrl.fire && (ctrl.act == A_STORE);
    assign do_final  = ctrl.fire && (ctrl.act == A_FINAL);
    assign do_reject = ctrl.fire && (ctrl.act == A_REJECT);
    assign do_good   = ctrl.fire && (ctrl.act == A_GOOD);
    assign do_emit   = ctrl.fire && (ctrl.act == A_EMIT);
    assign out_load  = do_reject || do_emit;

    // Condition flags for the sequencer.
    always_comb
    begin
        status.in_valid = in_valid;
        status.out_free = !out_valid_reg || out_ready;
        status.last = reading_reg && (pos_reg == LAST_POS);
        status.skip = !reading_reg && (byte_reg != header_high_reg);
        status.good = (cap1_reg == header_low_reg) && (cap2_reg == command_code_reg)
                      && (byte_reg == sum_reg);
        status.echo_done = (idx_reg == LAST_POS);
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_high_reg <= HEADER_HIGH_RST;
            header_low_reg <= HEADER_LOW_RST;
            command_code_reg <= COMMAND_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEADER_HIGH:  header_high_reg <= cfg_data;
                REG_HEADER_LOW:   header_low_reg <= cfg_data;
                REG_COMMAND_CODE: command_code_reg <= cfg_data;
                default:          header_high_reg <= header_high_reg;
            endcase
        end
    end

    // Frame control next values.
    always_comb
    begin
        reading_next = reading_reg;
        pos_next = pos_reg;
        sum_next = sum_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        if (do_store)
        begin
            reading_next = 1'b1;
            pos_next = pos_reg + POS_W'(1);
            sum_next = sum_reg + byte_reg;
        end
        if (do_reject || do_good)
        begin
            reading_next = 1'b0;
            pos_next = '0;
            sum_next = '0;
        end
        if (do_good)
        begin
            count_next = count_reg + 16'd1;
            idx_next = '0;
        end
        if (do_emit)
        begin
            idx_next = idx_reg + POS_W'(1);
        end
    end

    // Frame control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reading_reg <= 1'b0;
            pos_reg <= '0;
            sum_reg <= '0;
            count_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            reading_reg <= reading_next;
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
        end
    end

    // Byte latch and captures of frame bytes one and two.
    always_ff @(posedge clk)
    begin
        if (do_latch)
        begin
            byte_reg <= rx_byte;
        end
        if (do_store && (pos_reg == POS_W'(1)))
        begin
            cap1_reg <= byte_reg;
        end
        if (do_store && (pos_reg == POS_W'(2)))
        begin
            cap2_reg <= byte_reg;
        end
    end

    // Frame store: one write port, one registered read port.
    assign store_we = do_store || do_final;
    assign store_addr = do_final ? LAST_POS : pos_reg;

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_addr] <= byte_reg;
        end
        rd_data_reg <= store_mem[idx_reg];
    end

    // Result register.
    always_comb
    begin
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg <= do_reject ? KIND_REJECT : KIND_ECHO;
            out_data_reg <= do_reject ? 8'd0 : rd_data_reg;
            out_last_reg <= do_reject || (idx_reg == LAST_POS);
            out_count_reg <= count_reg;
        end
    end

    // Port drive.
    assign in_ready = ctrl.take_in;
    assign out_valid = out_valid_reg;
    assign kind = out_kind_reg;
    assign data_byte = out_data_reg;
    assign last = out_last_reg;
    assign good_count = out_count_reg;

    // Checks.
    `HCFR_ASSERT_NEXT(a_count_step, clk, rst_n, do_good, count_reg == $past(count_reg) + 16'd1)
    `HCFR_ASSERT_SAME(a_reject_form, clk, rst_n, out_valid && (kind == KIND_REJECT), last && (data_byte == 8'd0))
    `HCFR_ASSERT_SAME(a_no_take_on_load, clk, rst_n, in_ready, !out_load)
    `HCFR_ASSERT_SAME(a_pos_idle, clk, rst_n, !reading_reg, pos_reg == '0 && sum_reg == 8'd0)

endmodule
